// File: rtl/hts_pkg.sv
// Shared types, codes and pattern tables of the haptic and tone sequencer.
package hts_pkg;

   // Request modes
   localparam logic [2:0] MODE_EVENT       = 3'd0;
   localparam logic [2:0] MODE_TICK        = 3'd1;
   localparam logic [2:0] MODE_PULSE       = 3'd2;
   localparam logic [2:0] MODE_TONE        = 3'd3;
   localparam logic [2:0] MODE_STOP_MOTOR  = 3'd4;
   localparam logic [2:0] MODE_STOP_BUZZER = 3'd5;
   localparam logic [2:0] MODE_STOP_ALL    = 3'd6;

   // Command codes on both result channels
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_STOP = 2'd1;
   localparam logic [1:0] CMD_RUN  = 2'd2;

   // Register indexes
   localparam logic CSR_MOTOR_ENABLE  = 1'b0;
   localparam logic CSR_BUZZER_ENABLE = 1'b1;

   // Pattern ids that mark a direct pulse or tone
   localparam logic [2:0] MOT_DIRECT = 3'd7;
   localparam logic [3:0] BZ_DIRECT  = 4'd15;

   typedef struct packed {
      logic start;
      logic direct;
      logic stop;
      logic tick;
   } player_ctl_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] speed;
   } motor_res_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] freq;
      logic [15:0] length;
      logic [7:0]  volume;
   } buzzer_res_type;

   typedef struct packed {
      logic [7:0] speed;
      logic [7:0] dur;
   } mot_seg_type;

   typedef struct packed {
      logic [15:0] freq;
      logic [7:0]  dur;
      logic [7:0]  vol;
   } bz_note_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] id;
   } ev_motor_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] id;
   } ev_buzzer_type;

   // Segment count of each motor pattern
   function automatic logic [2:0] mot_len(input logic [2:0] id);
      logic [2:0] n;
      case (id)
         3'd0:    n = 3'd2;
         3'd1:    n = 3'd1;
         3'd2:    n = 3'd4;
         3'd3:    n = 3'd6;
         3'd4:    n = 3'd3;
         3'd5:    n = 3'd6;
         3'd6:    n = 3'd5;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

   // Motor segments: speed and duration in ms
   function automatic mot_seg_type mot_seg(input logic [2:0] id, input logic [2:0] stp);
      mot_seg_type s;
      case ({id, stp})
         {3'd0, 3'd0}: s = '{8'd192, 8'd30};
         {3'd0, 3'd1}: s = '{8'd96,  8'd20};
         {3'd1, 3'd0}: s = '{8'd200, 8'd80};
         {3'd2, 3'd0}: s = '{8'd255, 8'd40};
         {3'd2, 3'd1}: s = '{8'd0,   8'd80};
         {3'd2, 3'd2}: s = '{8'd255, 8'd40};
         {3'd2, 3'd3}: s = '{8'd0,   8'd60};
         {3'd3, 3'd0}: s = '{8'd192, 8'd50};
         {3'd3, 3'd1}: s = '{8'd0,   8'd60};
         {3'd3, 3'd2}: s = '{8'd192, 8'd50};
         {3'd3, 3'd3}: s = '{8'd0,   8'd60};
         {3'd3, 3'd4}: s = '{8'd192, 8'd50};
         {3'd3, 3'd5}: s = '{8'd0,   8'd50};
         {3'd4, 3'd0}: s = '{8'd128, 8'd50};
         {3'd4, 3'd1}: s = '{8'd255, 8'd80};
         {3'd4, 3'd2}: s = '{8'd96,  8'd40};
         {3'd5, 3'd0}: s = '{8'd255, 8'd30};
         {3'd5, 3'd1}: s = '{8'd0,   8'd40};
         {3'd5, 3'd2}: s = '{8'd255, 8'd30};
         {3'd5, 3'd3}: s = '{8'd0,   8'd40};
         {3'd5, 3'd4}: s = '{8'd255, 8'd30};
         {3'd5, 3'd5}: s = '{8'd0,   8'd50};
         {3'd6, 3'd0}: s = '{8'd80,  8'd100};
         {3'd6, 3'd1}: s = '{8'd160, 8'd100};
         {3'd6, 3'd2}: s = '{8'd255, 8'd150};
         {3'd6, 3'd3}: s = '{8'd160, 8'd100};
         {3'd6, 3'd4}: s = '{8'd80,  8'd100};
         default:      s = '0;
      endcase
      return s;
   endfunction

   // Note count of each buzzer sequence
   function automatic logic [1:0] bz_len(input logic [3:0] id);
      logic [1:0] n;
      case (id) inside
         4'd2, 4'd4, 4'd6, 4'd12, 4'd13: n = 2'd2;
         4'd3, 4'd5, 4'd7, 4'd14:        n = 2'd3;
         default:                        n = 2'd1;
      endcase
      return n;
   endfunction

   // Buzzer notes: frequency, duration, volume
   function automatic bz_note_type bz_note(input logic [3:0] id, input logic [1:0] stp);
      bz_note_type s;
      case ({id, stp})
         {4'd0,  2'd0}: s = '{16'd1200, 8'd40,  8'd60};
         {4'd1,  2'd0}: s = '{16'd800,  8'd100, 8'd80};
         {4'd2,  2'd0}: s = '{16'd400,  8'd40,  8'd80};
         {4'd2,  2'd1}: s = '{16'd400,  8'd40,  8'd80};
         {4'd3,  2'd0}: s = '{16'd1200, 8'd50,  8'd70};
         {4'd3,  2'd1}: s = '{16'd1400, 8'd50,  8'd70};
         {4'd3,  2'd2}: s = '{16'd1600, 8'd80,  8'd80};
         {4'd4,  2'd0}: s = '{16'd1200, 8'd80,  8'd80};
         {4'd4,  2'd1}: s = '{16'd1500, 8'd120, 8'd90};
         {4'd5,  2'd0}: s = '{16'd300,  8'd30,  8'd80};
         {4'd5,  2'd1}: s = '{16'd300,  8'd30,  8'd80};
         {4'd5,  2'd2}: s = '{16'd300,  8'd30,  8'd80};
         {4'd6,  2'd0}: s = '{16'd1000, 8'd40,  8'd80};
         {4'd6,  2'd1}: s = '{16'd1000, 8'd40,  8'd80};
         {4'd7,  2'd0}: s = '{16'd600,  8'd100, 8'd70};
         {4'd7,  2'd1}: s = '{16'd400,  8'd100, 8'd70};
         {4'd7,  2'd2}: s = '{16'd200,  8'd200, 8'd70};
         {4'd8,  2'd0}: s = '{16'd1200, 8'd15,  8'd50};
         {4'd9,  2'd0}: s = '{16'd1000, 8'd40,  8'd60};
         {4'd10, 2'd0}: s = '{16'd600,  8'd60,  8'd60};
         {4'd11, 2'd0}: s = '{16'd1000, 8'd100, 8'd80};
         {4'd12, 2'd0}: s = '{16'd1000, 8'd80,  8'd70};
         {4'd12, 2'd1}: s = '{16'd1500, 8'd120, 8'd80};
         {4'd13, 2'd0}: s = '{16'd1200, 8'd100, 8'd70};
         {4'd13, 2'd1}: s = '{16'd800,  8'd150, 8'd60};
         {4'd14, 2'd0}: s = '{16'd800,  8'd100, 8'd70};
         {4'd14, 2'd1}: s = '{16'd800,  8'd100, 8'd70};
         {4'd14, 2'd2}: s = '{16'd1200, 8'd150, 8'd80};
         default:       s = '0;
      endcase
      return s;
   endfunction

   // Event to motor pattern
   function automatic ev_motor_type ev_motor(input logic [4:0] ev);
      ev_motor_type m;
      case (ev) inside
         5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: m = '{1'b1, ev[2:0]};
         5'd11:                              m = '{1'b1, 3'd6};
         default:                            m = '{1'b0, 3'd0};
      endcase
      return m;
   endfunction

   // Event to buzzer sequence
   function automatic ev_buzzer_type ev_buzzer(input logic [4:0] ev);
      ev_buzzer_type b;
      case (ev) inside
         5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10:
                  b = '{1'b1, ev[3:0]};
         5'd13:   b = '{1'b1, 4'd11};
         5'd14:   b = '{1'b1, 4'd12};
         5'd15:   b = '{1'b1, 4'd13};
         5'd16:   b = '{1'b1, 4'd8};
         5'd17:   b = '{1'b1, 4'd14};
         default: b = '{1'b0, 4'd0};
      endcase
      return b;
   endfunction

endpackage

// File: rtl/haptic_tone_pattern_sequencer.sv
// Top level of the haptic and tone sequencer: request register, time, decode, result register.
//
//  channel  direction  handshake              word
//  req      in         req_valid / req_ready  mode, event code, direct pulse and tone fields
//  rsp      out        rsp_valid / rsp_ready  motor and buzzer commands, note, busy flags
//  csr      in         csr_valid / csr_ready  enable register index and write data
//
// A word is captured in the request register and, once the result register is free, is
// processed into it; one word is taken every cycle unless the result register stalls.
// The result register is the only stall point: req_ready drops only while a word
// waits in the request register behind an untaken result.
// Reset clears time, playback state and both valid flags and sets both enables.
// csr_ready is always high; there is no clearing pass.
module haptic_tone_pattern_sequencer #(
   parameter int TIME_WIDTH = 32,
   parameter int MAX_STEPS  = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [4:0]  req_event_code,
   input  logic [7:0]  req_pulse_speed,
   input  logic [15:0] req_tone_freq,
   input  logic [15:0] req_item_duration,
   input  logic [7:0]  req_tone_volume,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_motor_cmd,
   output logic [7:0]  rsp_motor_speed,
   output logic [1:0]  rsp_buzzer_cmd,
   output logic [15:0] rsp_note_freq,
   output logic [15:0] rsp_note_length,
   output logic [7:0]  rsp_note_volume,
   output logic        rsp_motor_busy,
   output logic        rsp_buzzer_busy,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic        csr_wdata
);
   import hts_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [2:0]  mode_ff;
   logic [4:0]  event_ff;
   logic [7:0]  speed_ff;
   logic [15:0] freq_ff;
   logic [15:0] dur_ff;
   logic [7:0]  vol_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TIME_WIDTH-1:0] time_ff, time_in;

   logic           advance;
   player_ctl_type motor_ctl, buzzer_ctl;
   ev_motor_type   ev_m;
   ev_buzzer_type  ev_b;
   motor_res_type  motor_res;
   buzzer_res_type buzzer_res;
   logic           motor_busy, buzzer_busy;
   logic           motor_csr_wr, buzzer_csr_wr;

   // Process the held word when the result register is free
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign csr_ready   = 1'b1;

   assign ev_m = ev_motor(event_ff);
   assign ev_b = ev_buzzer(event_ff);

   // Decode the mode into player controls
   always_comb begin
      motor_ctl  = '0;
      buzzer_ctl = '0;
      if (advance) begin
         unique case (mode_ff)
            MODE_EVENT: begin
               motor_ctl.start  = ev_m.valid;
               buzzer_ctl.start = ev_b.valid;
            end
            MODE_TICK: begin
               motor_ctl.tick  = 1'b1;
               buzzer_ctl.tick = 1'b1;
            end
            MODE_PULSE: begin
               motor_ctl.start  = 1'b1;
               motor_ctl.direct = 1'b1;
            end
            MODE_TONE: begin
               buzzer_ctl.start  = 1'b1;
               buzzer_ctl.direct = 1'b1;
            end
            MODE_STOP_MOTOR:  motor_ctl.stop = 1'b1;
            MODE_STOP_BUZZER: buzzer_ctl.stop = 1'b1;
            MODE_STOP_ALL: begin
               motor_ctl.stop  = 1'b1;
               buzzer_ctl.stop = 1'b1;
            end
            default: begin
               motor_ctl  = '0;
               buzzer_ctl = '0;
            end
         endcase
      end
   end

   // Advance the millisecond time on a tick
   assign time_in = motor_ctl.tick ? time_ff + TIME_WIDTH'(1) : time_ff;

   assign motor_csr_wr  = csr_valid && (csr_index == CSR_MOTOR_ENABLE);
   assign buzzer_csr_wr = csr_valid && (csr_index == CSR_BUZZER_ENABLE);

   hts_motor_player #(
      .TIME_WIDTH (TIME_WIDTH),
      .MAX_STEPS  (MAX_STEPS)
   ) u_motor (
      .clock          (clock),
      .reset          (reset),
      .ctl            (motor_ctl),
      .event_id       (ev_m.id),
      .pulse_speed    (speed_ff),
      .pulse_duration (dur_ff),
      .time_next      (time_in),
      .csr_wr         (motor_csr_wr),
      .csr_data       (csr_wdata),
      .result         (motor_res),
      .busy           (motor_busy)
   );

   hts_buzzer_player #(
      .TIME_WIDTH (TIME_WIDTH),
      .MAX_STEPS  (MAX_STEPS)
   ) u_buzzer (
      .clock         (clock),
      .reset         (reset),
      .ctl           (buzzer_ctl),
      .event_id      (ev_b.id),
      .tone_freq     (freq_ff),
      .tone_duration (dur_ff),
      .tone_volume   (vol_ff),
      .time_next     (time_in),
      .csr_wr        (buzzer_csr_wr),
      .csr_data      (csr_wdata),
      .result        (buzzer_res),
      .busy          (buzzer_busy)
   );

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff  <= req_mode;
         event_ff <= req_event_code;
         speed_ff <= req_pulse_speed;
         freq_ff  <= req_tone_freq;
         dur_ff   <= req_item_duration;
         vol_ff   <= req_tone_volume;
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_motor_cmd   <= motor_res.cmd;
         rsp_motor_speed <= motor_res.speed;
         rsp_buzzer_cmd  <= buzzer_res.cmd;
         rsp_note_freq   <= buzzer_res.freq;
         rsp_note_length <= buzzer_res.length;
         rsp_note_volume <= buzzer_res.volume;
         rsp_motor_busy  <= motor_busy;
         rsp_buzzer_busy <= buzzer_busy;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A processed word always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed word did not reach the result register");

   // A held request word stays put while it waits
   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(mode_ff) && $stable(dur_ff)))
      else $error("stalled request word changed");

   // A drive command always carries a speed
   a_drive_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_motor_cmd == CMD_RUN) |-> (rsp_motor_speed != 8'd0))
      else $error("drive command with zero speed");

   // Note fields are zero unless a tone is played
   a_note_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_buzzer_cmd != CMD_RUN) |->
         (rsp_note_freq == 16'd0 && rsp_note_length == 16'd0 && rsp_note_volume == 8'd0))
      else $error("note fields set without a play command");

   // Time moves only when a tick word is processed
   a_time_tick: assert property (@(posedge clock) disable iff (reset)
      !(advance && mode_ff == MODE_TICK) |=> $stable(time_ff))
      else $error("time changed without a tick");

endmodule

// File: rtl/hts_motor_player.sv
// Motor pattern player: enable, playback state and segment stepping.
module hts_motor_player #(
   parameter int TIME_WIDTH = 32,
   parameter int MAX_STEPS  = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hts_pkg::player_ctl_type ctl,
   input  logic [2:0]              event_id,
   input  logic [7:0]              pulse_speed,
   input  logic [15:0]             pulse_duration,
   input  logic [TIME_WIDTH-1:0]   time_next,
   input  logic                    csr_wr,
   input  logic                    csr_data,
   output hts_pkg::motor_res_type  result,
   output logic                    busy
);
   import hts_pkg::*;

   localparam logic [4:0] MaxSteps = 5'(MAX_STEPS);

   logic                  enable_ff, enable_in;
   logic                  playing_ff, playing_in;
   logic [2:0]            id_ff, id_in;
   logic [2:0]            step_ff, step_in;
   logic [TIME_WIDTH-1:0] deadline_ff, deadline_in;

   logic [2:0]  step_nx;
   logic        last_seg;
   logic        emit;
   logic [7:0]  emit_speed;
   logic [15:0] emit_dur;
   mot_seg_type first_seg, next_seg;

   assign step_nx   = step_ff + 3'd1;
   assign first_seg = mot_seg(event_id, 3'd0);
   assign next_seg  = mot_seg(id_ff, step_nx);
   assign last_seg  = ({2'b00, step_nx} >= {2'b00, mot_len(id_ff)}) ||
                      ({2'b00, step_nx} >= MaxSteps) || (id_ff == MOT_DIRECT);

   // Start, stop or advance the pattern
   always_comb begin
      enable_in   = enable_ff;
      playing_in  = playing_ff;
      id_in       = id_ff;
      step_in     = step_ff;
      deadline_in = deadline_ff;
      result      = '{CMD_NONE, 8'd0};
      emit        = 1'b0;
      emit_speed  = 8'd0;
      emit_dur    = 16'd0;
      if (ctl.start) begin
         if (enable_ff && !playing_ff) begin
            playing_in = 1'b1;
            id_in      = ctl.direct ? MOT_DIRECT : event_id;
            step_in    = 3'd0;
            emit       = 1'b1;
            emit_speed = ctl.direct ? pulse_speed : first_seg.speed;
            emit_dur   = ctl.direct ? pulse_duration : {8'd0, first_seg.dur};
         end
      end else if (ctl.stop) begin
         playing_in = 1'b0;
         result.cmd = CMD_STOP;
      end else if (ctl.tick && playing_ff && !(time_next < deadline_ff)) begin
         step_in = step_nx;
         if (last_seg) begin
            playing_in = 1'b0;
            result.cmd = CMD_STOP;
         end else begin
            emit       = 1'b1;
            emit_speed = next_seg.speed;
            emit_dur   = {8'd0, next_seg.dur};
         end
      end
      if (emit) begin
         result.cmd   = (emit_speed != 8'd0) ? CMD_RUN : CMD_STOP;
         result.speed = emit_speed;
         deadline_in  = time_next + TIME_WIDTH'(emit_dur);
      end
      // Disabling ends playback without a command
      if (csr_wr) begin
         enable_in = csr_data;
         if (!csr_data) begin
            playing_in = 1'b0;
         end
      end
   end

   assign busy = playing_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         playing_ff  <= 1'b0;
         id_ff       <= 3'd0;
         step_ff     <= 3'd0;
         deadline_ff <= '0;
      end else begin
         enable_ff   <= enable_in;
         playing_ff  <= playing_in;
         id_ff       <= id_in;
         step_ff     <= step_in;
         deadline_ff <= deadline_in;
      end
   end

endmodule

// File: rtl/hts_buzzer_player.sv
// Buzzer sequence player: enable, playback state and note stepping.
module hts_buzzer_player #(
   parameter int TIME_WIDTH = 32,
   parameter int MAX_STEPS  = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hts_pkg::player_ctl_type ctl,
   input  logic [3:0]              event_id,
   input  logic [15:0]             tone_freq,
   input  logic [15:0]             tone_duration,
   input  logic [7:0]              tone_volume,
   input  logic [TIME_WIDTH-1:0]   time_next,
   input  logic                    csr_wr,
   input  logic                    csr_data,
   output hts_pkg::buzzer_res_type result,
   output logic                    busy
);
   import hts_pkg::*;

   localparam logic [4:0] MaxSteps = 5'(MAX_STEPS);

   logic                  enable_ff, enable_in;
   logic                  playing_ff, playing_in;
   logic [3:0]            id_ff, id_in;
   logic [1:0]            step_ff, step_in;
   logic [TIME_WIDTH-1:0] deadline_ff, deadline_in;

   logic [1:0]  step_nx;
   logic        last_note;
   logic        emit;
   logic [15:0] emit_freq;
   logic [15:0] emit_dur;
   logic [7:0]  emit_vol;
   bz_note_type first_note, next_note;

   assign step_nx    = step_ff + 2'd1;
   assign first_note = bz_note(event_id, 2'd0);
   assign next_note  = bz_note(id_ff, step_nx);
   assign last_note  = ({3'b000, step_nx} >= {3'b000, bz_len(id_ff)}) ||
                       ({3'b000, step_nx} >= MaxSteps) || (id_ff == BZ_DIRECT);

   // Start, stop or advance the sequence
   always_comb begin
      enable_in   = enable_ff;
      playing_in  = playing_ff;
      id_in       = id_ff;
      step_in     = step_ff;
      deadline_in = deadline_ff;
      result      = '{CMD_NONE, 16'd0, 16'd0, 8'd0};
      emit        = 1'b0;
      emit_freq   = 16'd0;
      emit_dur    = 16'd0;
      emit_vol    = 8'd0;
      if (ctl.start) begin
         if (enable_ff && !playing_ff) begin
            playing_in = 1'b1;
            id_in      = ctl.direct ? BZ_DIRECT : event_id;
            step_in    = 2'd0;
            emit       = 1'b1;
            emit_freq  = ctl.direct ? tone_freq : first_note.freq;
            emit_dur   = ctl.direct ? tone_duration : {8'd0, first_note.dur};
            emit_vol   = ctl.direct ? tone_volume : first_note.vol;
         end
      end else if (ctl.stop) begin
         playing_in = 1'b0;
         result.cmd = CMD_STOP;
      end else if (ctl.tick && playing_ff && !(time_next < deadline_ff)) begin
         step_in = step_nx;
         if (last_note) begin
            playing_in = 1'b0;
            result.cmd = CMD_STOP;
         end else begin
            emit      = 1'b1;
            emit_freq = next_note.freq;
            emit_dur  = {8'd0, next_note.dur};
            emit_vol  = next_note.vol;
         end
      end
      // A rest or a silent note stops the buzzer but keeps the timing
      if (emit) begin
         if (emit_freq == 16'd0 || emit_vol == 8'd0) begin
            result.cmd = CMD_STOP;
         end else begin
            result = '{CMD_RUN, emit_freq, emit_dur, emit_vol};
         end
         deadline_in = time_next + TIME_WIDTH'(emit_dur);
      end
      // Disabling ends playback without a command
      if (csr_wr) begin
         enable_in = csr_data;
         if (!csr_data) begin
            playing_in = 1'b0;
         end
      end
   end

   assign busy = playing_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         playing_ff  <= 1'b0;
         id_ff       <= 4'd0;
         step_ff     <= 2'd0;
         deadline_ff <= '0;
      end else begin
         enable_ff   <= enable_in;
         playing_ff  <= playing_in;
         id_ff       <= id_in;
         step_ff     <= step_in;
         deadline_ff <= deadline_in;
      end
   end

endmodule

// File: sim/tb_haptic_tone_pattern_sequencer.sv
// Self-checking testbench for the haptic and tone sequencer: directed, enable and random traffic.
module tb_haptic_tone_pattern_sequencer;
   import hts_pkg::*;

   // Request modes and event codes not named in the package
   localparam logic [2:0] MODE_UNUSED  = 3'd7;
   localparam logic [4:0] EV_EAT       = 5'd0;
   localparam logic [4:0] EV_DIE       = 5'd2;
   localparam logic [4:0] EV_LEVEL_UP  = 5'd3;
   localparam logic [4:0] EV_SUCCESS   = 5'd4;
   localparam logic [4:0] EV_WARNING   = 5'd6;
   localparam logic [4:0] EV_RUMBLE    = 5'd11;
   localparam logic [4:0] EV_COUNTDOWN = 5'd17;
   localparam logic [4:0] EV_NONE      = 5'd18;
   localparam logic [4:0] EV_MAX_CODE  = 5'd31;

   localparam int STEP_CAP    = 6;
   localparam int MOTOR_PATS  = 7;
   localparam int TONE_SEQS   = 15;
   localparam int MOTOR_SLOTS = 6;
   localparam int TONE_SLOTS  = 3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [4:0]  ev;
      logic [7:0]  speed;
      logic [15:0] freq;
      logic [15:0] dur;
      logic [7:0]  vol;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  motor_cmd;
      logic [7:0]  motor_speed;
      logic [1:0]  buzzer_cmd;
      logic [15:0] note_freq;
      logic [15:0] note_length;
      logic [7:0]  note_volume;
      logic        motor_busy;
      logic        buzzer_busy;
   } cmd_word_type;

   // Pattern tables: motor {speed, ms}, six slots per pattern
   int unsigned motor_len_tab [8] = '{2, 1, 4, 6, 3, 6, 5, 1};
   logic [15:0] motor_seg_tab [42] = '{
      {8'd192, 8'd30}, {8'd96, 8'd20}, 16'd0, 16'd0, 16'd0, 16'd0,
      {8'd200, 8'd80}, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
      {8'd255, 8'd40}, {8'd0, 8'd80}, {8'd255, 8'd40}, {8'd0, 8'd60}, 16'd0, 16'd0,
      {8'd192, 8'd50}, {8'd0, 8'd60}, {8'd192, 8'd50}, {8'd0, 8'd60},
      {8'd192, 8'd50}, {8'd0, 8'd50},
      {8'd128, 8'd50}, {8'd255, 8'd80}, {8'd96, 8'd40}, 16'd0, 16'd0, 16'd0,
      {8'd255, 8'd30}, {8'd0, 8'd40}, {8'd255, 8'd30}, {8'd0, 8'd40},
      {8'd255, 8'd30}, {8'd0, 8'd50},
      {8'd80, 8'd100}, {8'd160, 8'd100}, {8'd255, 8'd150}, {8'd160, 8'd100},
      {8'd80, 8'd100}, 16'd0
   };

   // Note tables: {freq, ms, volume}, three slots per sequence
   int unsigned tone_len_tab [16] = '{1, 1, 2, 3, 2, 3, 2, 3, 1, 1, 1, 1, 2, 2, 3, 1};
   logic [31:0] tone_note_tab [45] = '{
      {16'd1200, 8'd40, 8'd60}, 32'd0, 32'd0,
      {16'd800, 8'd100, 8'd80}, 32'd0, 32'd0,
      {16'd400, 8'd40, 8'd80}, {16'd400, 8'd40, 8'd80}, 32'd0,
      {16'd1200, 8'd50, 8'd70}, {16'd1400, 8'd50, 8'd70}, {16'd1600, 8'd80, 8'd80},
      {16'd1200, 8'd80, 8'd80}, {16'd1500, 8'd120, 8'd90}, 32'd0,
      {16'd300, 8'd30, 8'd80}, {16'd300, 8'd30, 8'd80}, {16'd300, 8'd30, 8'd80},
      {16'd1000, 8'd40, 8'd80}, {16'd1000, 8'd40, 8'd80}, 32'd0,
      {16'd600, 8'd100, 8'd70}, {16'd400, 8'd100, 8'd70}, {16'd200, 8'd200, 8'd70},
      {16'd1200, 8'd15, 8'd50}, 32'd0, 32'd0,
      {16'd1000, 8'd40, 8'd60}, 32'd0, 32'd0,
      {16'd600, 8'd60, 8'd60}, 32'd0, 32'd0,
      {16'd1000, 8'd100, 8'd80}, 32'd0, 32'd0,
      {16'd1000, 8'd80, 8'd70}, {16'd1500, 8'd120, 8'd80}, 32'd0,
      {16'd1200, 8'd100, 8'd70}, {16'd800, 8'd150, 8'd60}, 32'd0,
      {16'd800, 8'd100, 8'd70}, {16'd800, 8'd100, 8'd70}, {16'd1200, 8'd150, 8'd80}
   };

   // Event to motor pattern (7 and up: none) and to note sequence (15 and up: none)
   int unsigned event_motor_tab [18] = '{0, 1, 2, 3, 4, 5, 8, 8, 8, 8, 8, 6, 8, 8, 8, 8, 8, 8};
   int unsigned event_tone_tab [18] =
      '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 16, 16, 11, 12, 13, 8, 14};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = '0;
   logic [4:0]  req_event_code = '0;
   logic [7:0]  req_pulse_speed = '0;
   logic [15:0] req_tone_freq = '0;
   logic [15:0] req_item_duration = '0;
   logic [7:0]  req_tone_volume = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_motor_cmd;
   logic [7:0]  rsp_motor_speed;
   logic [1:0]  rsp_buzzer_cmd;
   logic [15:0] rsp_note_freq;
   logic [15:0] rsp_note_length;
   logic [7:0]  rsp_note_volume;
   logic        rsp_motor_busy;
   logic        rsp_buzzer_busy;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic        csr_wdata = 1'b0;

   // Sequencer state as the checker sees it
   logic        motor_en = 1'b1;
   logic        buzzer_en = 1'b1;
   logic [31:0] ms_now = '0;
   logic        mot_on = 1'b0;
   logic [2:0]  mot_pat = '0;
   logic [2:0]  mot_idx = '0;
   logic [31:0] mot_due = '0;
   logic        buz_on = 1'b0;
   logic [3:0]  buz_pat = '0;
   logic [1:0]  buz_idx = '0;
   logic [31:0] buz_due = '0;
   cmd_word_type next_cmd;

   cmd_word_type pending_cmds [$];
   int unsigned words_sent = 0;
   int unsigned mismatches = 0;
   int unsigned snd_idle_pct = 0;
   int unsigned rcv_idle_pct = 0;

   haptic_tone_pattern_sequencer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_event_code    (req_event_code),
      .req_pulse_speed   (req_pulse_speed),
      .req_tone_freq     (req_tone_freq),
      .req_item_duration (req_item_duration),
      .req_tone_volume   (req_tone_volume),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_motor_cmd     (rsp_motor_cmd),
      .rsp_motor_speed   (rsp_motor_speed),
      .rsp_buzzer_cmd    (rsp_buzzer_cmd),
      .rsp_note_freq     (rsp_note_freq),
      .rsp_note_length   (rsp_note_length),
      .rsp_note_volume   (rsp_note_volume),
      .rsp_motor_busy    (rsp_motor_busy),
      .rsp_buzzer_busy   (rsp_buzzer_busy),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Motor segment output: zero speed means a stop command, timing runs either way
   function automatic void motor_drive(input logic [15:0] seg);
      if (seg[15:8] != 8'd0) begin
         next_cmd.motor_cmd = CMD_RUN;
         next_cmd.motor_speed = seg[15:8];
      end else begin
         next_cmd.motor_cmd = CMD_STOP;
         next_cmd.motor_speed = '0;
      end
      mot_due = ms_now + 32'(seg[7:0]);
   endfunction

   // Direct pulses carry a 16-bit length, so take it separately from the segment
   function automatic void motor_begin(input logic [2:0] pat, input logic [7:0] spd,
                                       input logic [15:0] ms);
      if (!motor_en || mot_on)
         return;
      mot_on = 1'b1;
      mot_pat = pat;
      mot_idx = '0;
      motor_drive({spd, 8'd0});
      mot_due = ms_now + 32'(ms);
   endfunction

   // Rest note or zero volume gives a stop command, timing runs either way
   function automatic void buzzer_play(input logic [15:0] freq, input logic [15:0] ms,
                                       input logic [7:0] vol);
      if (freq == 16'd0 || vol == 8'd0) begin
         next_cmd.buzzer_cmd = CMD_STOP;
         next_cmd.note_freq = '0;
         next_cmd.note_length = '0;
         next_cmd.note_volume = '0;
      end else begin
         next_cmd.buzzer_cmd = CMD_RUN;
         next_cmd.note_freq = freq;
         next_cmd.note_length = ms;
         next_cmd.note_volume = vol;
      end
      buz_due = ms_now + 32'(ms);
   endfunction

   function automatic void buzzer_begin(input logic [3:0] seq, input logic [15:0] freq,
                                        input logic [15:0] ms, input logic [7:0] vol);
      if (!buzzer_en || buz_on)
         return;
      buz_on = 1'b1;
      buz_pat = seq;
      buz_idx = '0;
      buzzer_play(freq, ms, vol);
   endfunction

   function automatic void motor_halt();
      mot_on = 1'b0;
      next_cmd.motor_cmd = CMD_STOP;
      next_cmd.motor_speed = '0;
   endfunction

   function automatic void buzzer_halt();
      buz_on = 1'b0;
      next_cmd.buzzer_cmd = CMD_STOP;
      next_cmd.note_freq = '0;
      next_cmd.note_length = '0;
      next_cmd.note_volume = '0;
   endfunction

   // Commands and busy flags caused by one request word
   function automatic cmd_word_type sequencer_step(input req_word_type w);
      int unsigned pat, seq, steps;
      logic [31:0] note;
      next_cmd = '0;
      case (w.mode)
         MODE_EVENT: begin
            if (w.ev < EV_NONE) begin
               pat = event_motor_tab[w.ev];
               seq = event_tone_tab[w.ev];
               if (pat < MOTOR_PATS)
                  motor_begin(3'(pat), motor_seg_tab[pat * MOTOR_SLOTS][15:8],
                              16'(motor_seg_tab[pat * MOTOR_SLOTS][7:0]));
               if (seq < TONE_SEQS) begin
                  note = tone_note_tab[seq * TONE_SLOTS];
                  buzzer_begin(4'(seq), note[31:16], 16'(note[15:8]), note[7:0]);
               end
            end
         end
         MODE_TICK: begin
            // Advance time, then the motor, then the buzzer
            ms_now = ms_now + 32'd1;
            if (mot_on && ms_now >= mot_due) begin
               steps = motor_len_tab[mot_pat] < STEP_CAP ? motor_len_tab[mot_pat] : STEP_CAP;
               mot_idx = mot_idx + 3'd1;
               if (mot_idx >= steps || mot_pat == MOT_DIRECT)
                  motor_halt();
               else
                  motor_drive(motor_seg_tab[mot_pat * MOTOR_SLOTS + mot_idx]);
            end
            if (buz_on && ms_now >= buz_due) begin
               steps = tone_len_tab[buz_pat] < STEP_CAP ? tone_len_tab[buz_pat] : STEP_CAP;
               buz_idx = buz_idx + 2'd1;
               if (buz_idx >= steps || buz_pat == BZ_DIRECT) begin
                  buzzer_halt();
               end else begin
                  note = tone_note_tab[buz_pat * TONE_SLOTS + buz_idx];
                  buzzer_play(note[31:16], 16'(note[15:8]), note[7:0]);
               end
            end
         end
         MODE_PULSE:       motor_begin(MOT_DIRECT, w.speed, w.dur);
         MODE_TONE:        buzzer_begin(BZ_DIRECT, w.freq, w.dur, w.vol);
         MODE_STOP_MOTOR:  motor_halt();
         MODE_STOP_BUZZER: buzzer_halt();
         MODE_STOP_ALL: begin
            motor_halt();
            buzzer_halt();
         end
         default: ;
      endcase
      next_cmd.motor_busy = mot_on;
      next_cmd.buzzer_busy = buz_on;
      return next_cmd;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      w.mode = 3'($urandom_range(7));
      w.ev = 5'($urandom_range(31));
      w.speed = 8'($urandom_range(255));
      w.freq = 16'($urandom_range(65535));
      w.dur = 16'($urandom_range(65535));
      w.vol = 8'($urandom_range(255));
      return w;
   endfunction

   // Mostly short lengths so patterns can finish, a few long ones
   function automatic logic [15:0] random_ms();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 85)
         return 16'($urandom_range(150));
      else if (pick < 95)
         return 16'($urandom_range(2000, 151));
      return 16'($urandom_range(65535));
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Send one word; returns at a falling edge with valid still high
   task automatic send_word(input req_word_type w);
      // Idle the sender while a random draw falls under snd_idle_pct
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= w.mode;
      req_event_code <= w.ev;
      req_pulse_speed <= w.speed;
      req_tone_freq <= w.freq;
      req_item_duration <= w.dur;
      req_tone_volume <= w.vol;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_cmds.push_back(sequencer_step(w));
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_req(input logic [2:0] mode, input logic [4:0] ev, input logic [7:0] spd,
                           input logic [15:0] freq, input logic [15:0] ms,
                           input logic [7:0] vol);
      send_word('{mode, ev, spd, freq, ms, vol});
   endtask

   task automatic send_ticks(input int unsigned count);
      req_word_type w;
      repeat (count) begin
         w = random_word();
         w.mode = MODE_TICK;
         send_word(w);
      end
   endtask

   // Hold the request side low until every command is back and the pipe is empty
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic val);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      // Clearing an enable drops playback without a command
      if (idx == CSR_MOTOR_ENABLE) begin
         motor_en = val;
         if (!val)
            mot_on = 1'b0;
      end else begin
         buzzer_en = val;
         if (!val)
            buz_on = 1'b0;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_cases();
      send_req(MODE_EVENT, EV_EAT, 8'd0, 16'd0, 16'd0, 8'd0);
      // Busy channels ignore a second start
      send_req(MODE_EVENT, EV_EAT, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_req(MODE_STOP_ALL, EV_EAT, 8'd0, 16'd0, 16'd0, 8'd0);
      // Stops on idle channels still give a stop command
      send_req(MODE_STOP_MOTOR, EV_NONE, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_STOP_BUZZER, EV_NONE, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_EVENT, EV_NONE, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_EVENT, EV_MAX_CODE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_req(MODE_UNUSED, EV_EAT, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      // Zero speed, rest note and zero volume give stop commands but keep timing
      send_req(MODE_PULSE, EV_EAT, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_TONE, EV_EAT, 8'd0, 16'd0, 16'd0, 8'hFF);
      send_ticks(1);
      send_req(MODE_TONE, EV_EAT, 8'd0, 16'd1000, 16'd1, 8'd0);
      send_req(MODE_PULSE, EV_EAT, 8'hFF, 16'd0, 16'hFFFF, 8'd0);
      send_ticks(1);
      send_req(MODE_TONE, EV_EAT, 8'd0, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_req(MODE_PULSE, EV_EAT, 8'd128, 16'd0, 16'd10, 8'd0);
      send_req(MODE_EVENT, EV_COUNTDOWN, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_STOP_ALL, EV_EAT, 8'd0, 16'd0, 16'd0, 8'd0);
      // Events with a pattern for one channel only
      send_req(MODE_EVENT, EV_RUMBLE, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_EVENT, EV_WARNING, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_STOP_ALL, EV_EAT, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_EVENT, EV_DIE, 8'd0, 16'd0, 16'd0, 8'd0);
      send_ticks(3);
   endtask

   task automatic test_enable_control();
      write_csr(CSR_MOTOR_ENABLE, 1'b0);
      send_req(MODE_STOP_ALL, EV_EAT, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_EVENT, EV_EAT, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_PULSE, EV_EAT, 8'd200, 16'd0, 16'd50, 8'd0);
      // Disable the buzzer mid-note: playback ends silently
      write_csr(CSR_BUZZER_ENABLE, 1'b0);
      send_ticks(2);
      send_req(MODE_EVENT, EV_LEVEL_UP, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_TONE, EV_EAT, 8'd0, 16'd440, 16'd20, 8'd90);
      send_req(MODE_STOP_ALL, EV_EAT, 8'd0, 16'd0, 16'd0, 8'd0);
      write_csr(CSR_MOTOR_ENABLE, 1'b1);
      write_csr(CSR_BUZZER_ENABLE, 1'b1);
      send_req(MODE_EVENT, EV_RUMBLE, 8'd0, 16'd0, 16'd0, 8'd0);
      send_req(MODE_EVENT, EV_SUCCESS, 8'd0, 16'd0, 16'd0, 8'd0);
      write_csr(CSR_MOTOR_ENABLE, 1'b0);
      send_ticks(90);
      write_csr(CSR_MOTOR_ENABLE, 1'b1);
      send_req(MODE_STOP_ALL, EV_EAT, 8'd0, 16'd0, 16'd0, 8'd0);
   endtask

   // Random requests of every mode, each followed by a burst of ticks
   task automatic test_random_traffic(input logic mot_cfg, input logic buz_cfg,
                                      input int unsigned count);
      req_word_type w;
      int unsigned pick, stop_at;
      write_csr(CSR_MOTOR_ENABLE, mot_cfg);
      write_csr(CSR_BUZZER_ENABLE, buz_cfg);
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         w = random_word();
         pick = $urandom_range(99);
         if (pick < 40) begin
            w.mode = MODE_EVENT;
            w.ev = 5'($urandom_range(EV_COUNTDOWN));
         end else if (pick < 52) begin
            w.mode = MODE_PULSE;
            if ($urandom_range(9) == 0)
               w.speed = '0;
            w.dur = random_ms();
         end else if (pick < 64) begin
            w.mode = MODE_TONE;
            if ($urandom_range(9) == 0)
               w.freq = '0;
            if ($urandom_range(9) == 0)
               w.vol = '0;
            w.dur = random_ms();
         end else if (pick < 74) begin
            case ($urandom_range(2))
               0:       w.mode = MODE_STOP_MOTOR;
               1:       w.mode = MODE_STOP_BUZZER;
               default: w.mode = MODE_STOP_ALL;
            endcase
         end else if (pick < 78) begin
            // Noise: unused mode or an event code past the table
            if ($urandom_range(1) == 0) begin
               w.mode = MODE_UNUSED;
            end else begin
               w.mode = MODE_EVENT;
               w.ev = 5'($urandom_range(EV_MAX_CODE, EV_NONE));
            end
         end else begin
            w.mode = MODE_TICK;
         end
         send_word(w);
         send_ticks($urandom_range(60, 1));
      end
   endtask

   // Receiver stalls
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);

   // Compare each taken result with the oldest predicted command word
   always @(posedge clock) begin : check_results
      cmd_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual cmd %0d/%0d",
                     $time, rsp_motor_cmd, rsp_buzzer_cmd);
            mismatches++;
         end else begin
            want = pending_cmds.pop_front();
            check_field("motor_cmd", want.motor_cmd, rsp_motor_cmd);
            check_field("motor_speed", want.motor_speed, rsp_motor_speed);
            check_field("buzzer_cmd", want.buzzer_cmd, rsp_buzzer_cmd);
            check_field("note_freq", want.note_freq, rsp_note_freq);
            check_field("note_length", want.note_length, rsp_note_length);
            check_field("note_volume", want.note_volume, rsp_note_volume);
            check_field("motor_busy", want.motor_busy, rsp_motor_busy);
            check_field("buzzer_busy", want.buzzer_busy, rsp_buzzer_busy);
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      snd_idle_pct = 20;
      rcv_idle_pct = 62;
      test_directed_cases();
      test_enable_control();
      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               snd_idle_pct = 20;
               rcv_idle_pct = 62;
            end
            1: begin
               snd_idle_pct = 62;
               rcv_idle_pct = 20;
            end
            default: begin
               snd_idle_pct = 0;
               rcv_idle_pct = 0;
            end
         endcase
         test_random_traffic(1'b1, 1'b1, 340);
         test_random_traffic(1'b0, 1'b1, 90);
         test_random_traffic(1'b1, 1'b0, 90);
         test_random_traffic(1'b0, 1'b0, 25);
      end
      drain_pipeline();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && pending_cmds.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
rtl/hts_pkg.sv
rtl/hts_motor_player.sv
rtl/hts_buzzer_player.sv
rtl/haptic_tone_pattern_sequencer.sv
sim/tb_haptic_tone_pattern_sequencer.sv
